[rtl/core/prec_eval_pkg.sv]
// Shared types and constants for the precedence expression evaluator.
// Depends on nothing; imported by rtl/core/precedence_expression_evaluator.sv.
package prec_eval_pkg;

   // Q16.16 word format
   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // Widths of the multiply product and of the divide dividend/quotient
   localparam int PROD_BITS = 2 * WORD_BITS;
   localparam int QUO_BITS  = WORD_BITS + FRAC_BITS;
   localparam int MULF_BITS = PROD_BITS - FRAC_BITS + 1;
   localparam int FIX_BITS  = (MULF_BITS > QUO_BITS + 1) ? MULF_BITS : QUO_BITS + 1;
   localparam int STEP_BITS = $clog2(QUO_BITS + 1);

   typedef logic signed [WORD_BITS-1:0] word_type;
   typedef logic [WORD_BITS-1:0]        mag_type;
   typedef logic [1:0]                  op_type;

   // Operator codes
   localparam op_type OP_ADD = 2'd0;
   localparam op_type OP_SUB = 2'd1;
   localparam op_type OP_MUL = 2'd2;
   localparam op_type OP_DIV = 2'd3;

   // Token kinds
   localparam logic KIND_NUMBER   = 1'b0;
   localparam logic KIND_OPERATOR = 1'b1;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

   localparam logic [PROD_BITS-1:0] FRAC_MASK =
      (PROD_BITS'(1) << FRAC_BITS) - PROD_BITS'(1);

endpackage

[rtl/core/precedence_expression_evaluator.sv]
// Four-function calculator with operator precedence on a token stream.
// Depends on rtl/core/prec_eval_pkg.sv (types, operator codes, word format).
//
// Usage
//   Request channel (req_*): one token per transaction. A number token carries a
//   signed Q16.16 value, an operator token carries add, subtract, multiply or
//   divide. Multiply and divide bind tighter than add and subtract. Set
//   req_end_of_expression on the last token of an expression.
//   Response channel (rsp_*): one transaction per expression, carrying the value
//   and the sticky divide-by-zero and overflow flags; evaluation state then
//   returns to its reset values for the next expression.
// Sequencing
//   Operator tokens and add/subtract numbers: handled in the accept step alone.
//   Multiply numbers: accept, 32x32 multiply, saturate.
//   Divide numbers: accept, 48 steps of the restoring subtract/compare unit
//   (one per quotient bit), saturate; a zero divisor saturates in the accept step.
//   An end token then passes through the emit step to load the response register.
//   req_stall is high while a token is being worked on.
// Reset and stalls
//   Synchronous reset clears the running sum, term, flags and pending operator
//   (add) and empties the response register. The response register holds its
//   transaction while rsp_stall is high; new tokens are still accepted, and only
//   a following end token waits in the emit step for the register to free up.
module precedence_expression_evaluator (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_token_kind,
   input  prec_eval_pkg::op_type     req_operation,
   input  prec_eval_pkg::word_type   req_number_value,
   input  logic                      req_end_of_expression,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output prec_eval_pkg::word_type   rsp_expression_value,
   output logic                      rsp_divide_by_zero,
   output logic                      rsp_overflow
);
   import prec_eval_pkg::*;

   // Sequencer states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_FIX  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   localparam logic [STEP_BITS-1:0] DIV_STEPS = STEP_BITS'(QUO_BITS);

   // Control and evaluation state
   logic [2:0]           state_ff, state_in;
   word_type             sum_ff, sum_in;
   word_type             term_ff, term_in;
   op_type               pend_ff, pend_in;
   logic                 zdiv_ff, zdiv_in;
   logic                 ovf_ff, ovf_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // Working registers of the shared unit
   logic                 end_ff, end_in;
   logic                 neg_ff, neg_in;
   logic                 is_div_ff, is_div_in;
   mag_type              dsr_ff, dsr_in;
   logic [PROD_BITS-1:0] wide_ff, wide_in;
   mag_type              rem_ff, rem_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   word_type             rsp_value_ff, rsp_value_in;
   logic                 rsp_zdiv_ff, rsp_zdiv_in;
   logic                 rsp_ovf_ff, rsp_ovf_in;

   // Combinational helpers
   logic                 req_accept;
   logic [WORD_BITS:0]   add_wide;
   logic                 add_ovf;
   word_type             add_sat;
   mag_type              term_mag, num_mag;
   logic [QUO_BITS-1:0]  dvd;
   logic [WORD_BITS:0]   rem_sh, rem_diff;
   logic                 rem_ge;
   logic [FIX_BITS-1:0]  fix_mag, fix_limit;
   logic                 fix_round, fix_ovf;
   word_type             fix_word;
   logic                 emit_load;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != ST_IDLE);

   // Shared saturating adder: always sum plus term
   assign add_wide = {sum_ff[WORD_BITS-1], sum_ff} + {term_ff[WORD_BITS-1], term_ff};
   assign add_ovf  = add_wide[WORD_BITS] != add_wide[WORD_BITS-1];
   assign add_sat  = add_ovf ? (add_wide[WORD_BITS] ? WORD_MIN : WORD_MAX)
                             : word_type'(add_wide[WORD_BITS-1:0]);

   // Operand magnitudes
   assign term_mag = term_ff[WORD_BITS-1] ? (~mag_type'(term_ff) + mag_type'(1))
                                          : mag_type'(term_ff);
   assign num_mag  = req_number_value[WORD_BITS-1]
                     ? (~mag_type'(req_number_value) + mag_type'(1))
                     : mag_type'(req_number_value);

   // Restoring divide step: shift in the next dividend bit, subtract if it fits
   assign dvd      = wide_ff[QUO_BITS-1:0];
   assign rem_sh   = {rem_ff, dvd[QUO_BITS-1]};
   assign rem_ge   = rem_sh >= {1'b0, dsr_ff};
   assign rem_diff = rem_sh - {1'b0, dsr_ff};

   // Result magnitude: quotient as is, product scaled down with floor rounding
   assign fix_round = neg_ff && ((wide_ff & FRAC_MASK) != '0);
   always_comb begin
      if (is_div_ff) begin
         fix_mag = FIX_BITS'(dvd);
      end else begin
         fix_mag = FIX_BITS'(wide_ff >> FRAC_BITS) + FIX_BITS'(fix_round);
      end
   end
   assign fix_limit = neg_ff ? (FIX_BITS'(1) << (WORD_BITS - 1))
                             : FIX_BITS'(WORD_MAX);
   assign fix_ovf   = fix_mag > fix_limit;
   always_comb begin
      if (fix_ovf) begin
         fix_word = neg_ff ? WORD_MIN : WORD_MAX;
      end else if (neg_ff) begin
         fix_word = word_type'(~fix_mag[WORD_BITS-1:0] + mag_type'(1));
      end else begin
         fix_word = word_type'(fix_mag[WORD_BITS-1:0]);
      end
   end

   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sum_in       = sum_ff;
      term_in      = term_ff;
      pend_in      = pend_ff;
      zdiv_in      = zdiv_ff;
      ovf_in       = ovf_ff;
      end_in       = end_ff;
      neg_in       = neg_ff;
      is_div_in    = is_div_ff;
      dsr_in       = dsr_ff;
      wide_in      = wide_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_value_in = rsp_value_ff;
      rsp_zdiv_in  = rsp_zdiv_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               end_in   = req_end_of_expression;
               state_in = req_end_of_expression ? ST_EMIT : ST_IDLE;
               if (req_token_kind == KIND_OPERATOR) begin
                  pend_in = req_operation;
               end else begin
                  unique case (pend_ff) inside
                     OP_ADD, OP_SUB: begin
                        // Fold the finished term into the sum, start a new term
                        sum_in = add_sat;
                        ovf_in = ovf_ff | add_ovf;
                        if (pend_ff == OP_SUB) begin
                           if (req_number_value == WORD_MIN) begin
                              term_in = WORD_MAX;
                              ovf_in  = 1'b1;
                           end else begin
                              term_in = -req_number_value;
                           end
                        end else begin
                           term_in = req_number_value;
                        end
                     end
                     OP_MUL: begin
                        neg_in    = term_ff[WORD_BITS-1] != req_number_value[WORD_BITS-1];
                        is_div_in = 1'b0;
                        dsr_in    = num_mag;
                        wide_in   = PROD_BITS'(term_mag);
                        state_in  = ST_MUL;
                     end
                     OP_DIV: begin
                        if (req_number_value == '0) begin
                           term_in = term_ff[WORD_BITS-1] ? WORD_MIN : WORD_MAX;
                           zdiv_in = 1'b1;
                        end else begin
                           neg_in    = term_ff[WORD_BITS-1] != req_number_value[WORD_BITS-1];
                           is_div_in = 1'b1;
                           dsr_in    = num_mag;
                           wide_in   = PROD_BITS'({term_mag, {FRAC_BITS{1'b0}}});
                           rem_in    = '0;
                           step_in   = '0;
                           state_in  = ST_DIV;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_MUL: begin
            wide_in  = PROD_BITS'(wide_ff[WORD_BITS-1:0]) * PROD_BITS'(dsr_ff);
            state_in = ST_FIX;
         end
         ST_DIV: begin
            rem_in  = rem_ge ? rem_diff[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
            wide_in = PROD_BITS'({dvd[QUO_BITS-2:0], rem_ge});
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == DIV_STEPS - STEP_BITS'(1)) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            term_in  = fix_word;
            ovf_in   = ovf_ff | fix_ovf;
            state_in = end_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            // Wait for the response register, then clear for the next expression
            if (emit_load) begin
               rsp_value_in = add_sat;
               rsp_zdiv_in  = zdiv_ff;
               rsp_ovf_in   = ovf_ff | add_ovf;
               rsp_valid_in = 1'b1;
               sum_in       = '0;
               term_in      = '0;
               pend_in      = OP_ADD;
               zdiv_in      = 1'b0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         term_ff      <= '0;
         pend_ff      <= OP_ADD;
         zdiv_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         term_ff      <= term_in;
         pend_ff      <= pend_in;
         zdiv_ff      <= zdiv_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      end_ff       <= end_in;
      neg_ff       <= neg_in;
      is_div_ff    <= is_div_in;
      dsr_ff       <= dsr_in;
      wide_ff      <= wide_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_value_ff <= rsp_value_in;
      rsp_zdiv_ff  <= rsp_zdiv_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_expression_value = rsp_value_ff;
   assign rsp_divide_by_zero   = rsp_zdiv_ff;
   assign rsp_overflow         = rsp_ovf_ff;

   // Divide step counter stays inside the quotient width
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (step_ff < DIV_STEPS))
      else $error("divide step counter out of range");

   // Partial remainder always below the divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, rem_ff} < {1'b0, dsr_ff}))
      else $error("divide remainder not below divisor");

   // An end token never drops straight back to idle
   assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_end_of_expression) |=> (state_ff != ST_IDLE))
      else $error("end token accepted without emitting");

   // Emitting a response clears the evaluation state
   assert property (@(posedge clock) disable iff (reset)
      emit_load |=> (sum_ff == '0 && term_ff == '0 && !zdiv_ff && !ovf_ff
                     && pend_ff == OP_ADD && rsp_valid_ff))
      else $error("evaluation state not cleared after emit");

endmodule
